[rtl/crc16_checked_reply_deframer_core_defines.svh]
// Assertion macros shared by the deframer checker.
// Depends on nothing; include by bare file name.
`ifndef CRC16_CHECKED_REPLY_DEFRAMER_CORE_DEFINES_SVH
`define CRC16_CHECKED_REPLY_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRCDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRCDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication that is also checked across reset.
`define CRCDF_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

[rtl/crcdf_pkg.sv]
// Shared constants, types and the byte-wide CRC-16/XMODEM update of the deframer.
// Depends on nothing; every deframer module imports it.
package crcdf_pkg;

  localparam int MAX_FRAME_BYTES = 50;

  // Position counter must hold L+2 for the largest legal length.
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 3);

  localparam logic [7:0]  SYNC_BYTE     = 8'hF2;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'h0000;
  localparam logic [7:0]  MIN_FRAME_LEN = 8'd3;
  localparam logic [7:0]  MAX_FRAME_LEN = 8'(MAX_FRAME_BYTES);

  localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LEN    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CMD    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CODE   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_VAL_LO = POS_W'(4);
  localparam logic [POS_W-1:0] POS_VAL_HI = POS_W'(5);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic          valid;
    frame_status_t status;
    logic [7:0]    cmd;
    logic [7:0]    code;
    logic [15:0]   value;
  } result_t;

  // MSB-first CRC-16 update over one byte, no reflection.
  function automatic logic [15:0] crc16_take(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/crcdf_in_stage.sv]
// Input register of the deframer: captures one received byte per transaction.
// Depends on crcdf_pkg.
module crcdf_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  proceed,
  output crcdf_pkg::byte_item_t item
);
  import crcdf_pkg::*;

  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] data_r;
  logic       accept;

  // The held byte leaves whenever the frame logic advances.
  assign in_stall = hold_valid_r && !proceed;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (proceed) begin
      hold_valid_nxt = 1'b0;
    end else begin
      hold_valid_nxt = hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_rx_byte;
    end
  end

  assign item.valid = hold_valid_r;
  assign item.data  = data_r;

endmodule

[rtl/crcdf_frame_ctrl.sv]
// Frame tracking of the deframer: position counter, running CRC, captured fields.
// Depends on crcdf_pkg; presents at most one result per processed byte.
module crcdf_frame_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crcdf_pkg::byte_item_t item,
  input  logic                  proceed,
  output crcdf_pkg::result_t    res
);
  import crcdf_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             mismatch_r, mismatch_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [15:0]      value_r, value_nxt;
  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] len_p1;
  logic [7:0]       b;
  logic             step;

  assign b       = item.data;
  assign step    = item.valid && proceed;
  assign len_ext = POS_W'(len_r);
  assign len_p1  = len_ext + POS_W'(1);

  always_comb begin
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    mismatch_nxt = mismatch_r;
    cmd_nxt      = cmd_r;
    code_nxt     = code_r;
    value_nxt    = value_r;
    res          = '0;
    res.status   = ST_OK;

    if (pos_r == POS_HUNT) begin
      // Anything but the sync byte is idle line noise.
      if (b == SYNC_BYTE) begin
        pos_nxt      = POS_LEN;
        len_nxt      = 8'h00;
        crc_nxt      = CRC_INIT;
        mismatch_nxt = 1'b0;
        cmd_nxt      = 8'h00;
        code_nxt     = 8'h00;
        value_nxt    = 16'h0000;
      end
    end else if (pos_r == POS_LEN) begin
      if (b < MIN_FRAME_LEN || b > MAX_FRAME_LEN) begin
        pos_nxt    = POS_HUNT;
        len_nxt    = 8'h00;
        res.valid  = 1'b1;
        res.status = ST_LEN_ERR;
      end else begin
        len_nxt = b;
        crc_nxt = crc16_take(CRC_INIT, b);
        pos_nxt = POS_CMD;
      end
    end else begin
      // Field capture happens by position, even when it overlaps check bytes.
      if (pos_r == POS_CMD) begin
        cmd_nxt = b;
      end else if (pos_r == POS_CODE) begin
        code_nxt = b;
      end else if (pos_r == POS_VAL_LO) begin
        value_nxt = {value_r[15:8], b};
      end else if (pos_r == POS_VAL_HI) begin
        value_nxt = {b, value_r[7:0]};
      end

      pos_nxt = pos_r + POS_W'(1);
      if (pos_r < len_ext) begin
        crc_nxt = crc16_take(crc_r, b);
      end else if (pos_r == len_ext) begin
        if (b != crc_r[15:8]) begin
          mismatch_nxt = 1'b1;
        end
      end else if (pos_r == len_p1) begin
        if (b != crc_r[7:0]) begin
          mismatch_nxt = 1'b1;
        end
      end else begin
        // End byte: its value is ignored.
        pos_nxt    = POS_HUNT;
        res.valid  = 1'b1;
        res.status = mismatch_r ? ST_CRC_ERR : ST_OK;
        res.cmd    = cmd_nxt;
        res.code   = code_nxt;
        res.value  = value_nxt;
      end
    end

    res.valid = res.valid && item.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_HUNT;
      len_r      <= 8'h00;
      crc_r      <= CRC_INIT;
      mismatch_r <= 1'b0;
      cmd_r      <= 8'h00;
      code_r     <= 8'h00;
      value_r    <= 16'h0000;
    end else if (step) begin
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      mismatch_r <= mismatch_nxt;
      cmd_r      <= cmd_nxt;
      code_r     <= code_nxt;
      value_r    <= value_nxt;
    end
  end

endmodule

[rtl/crcdf_out_stage.sv]
// Result register of the deframer: holds one result until its transaction completes.
// Depends on crcdf_pkg; tells the upstream stages when they may advance.
module crcdf_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  crcdf_pkg::result_t res,
  output logic               proceed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_status,
  output logic [7:0]         out_command_code,
  output logic [7:0]         out_reply_code,
  output logic [15:0]        out_reply_value
);
  import crcdf_pkg::*;

  logic          valid_r, valid_nxt;
  frame_status_t status_r;
  logic [7:0]    cmd_r;
  logic [7:0]    code_r;
  logic [15:0]   value_r;
  logic          load;

  // The register is free when empty or when its result is taken this cycle.
  assign proceed = !valid_r || !out_stall;
  assign load    = proceed && res.valid;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (proceed) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= res.status;
      cmd_r    <= res.cmd;
      code_r   <= res.code;
      value_r  <= res.value;
    end
  end

  assign out_valid        = valid_r;
  assign out_frame_status = status_r;
  assign out_command_code = cmd_r;
  assign out_reply_code   = code_r;
  assign out_reply_value  = value_r;

endmodule

[rtl/crc16_checked_reply_deframer_core.sv]
// A byte that ends a frame is loaded into the input register when it is taken; its result
// is loaded into the result register once the stages advance. Throughput: one byte per
// cycle while out_stall is low; the CRC update and position compare are combinational.
// A result waiting under out_stall holds the byte behind it in the input register.
// Reset (rst_n low, synchronous) empties both registers and returns the deframer to hunting.
module crc16_checked_reply_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_command_code,
  output logic [7:0]  out_reply_code,
  output logic [15:0] out_reply_value
);
  import crcdf_pkg::*;

  // The byte held in the input register, and whether the stages may advance.
  byte_item_t item;
  logic       proceed;

  // The result that the held byte causes, if any.
  result_t    res;

  // Input register. It accepts a new byte in the same cycle that the held one moves on,
  // so back-to-back transactions flow without bubbles.
  crcdf_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .proceed    (proceed),
    .item       (item)
  );

  // Frame tracking. It hunts for the sync byte, validates the length byte, folds the
  // CRC over bytes one to L-1, compares the two check bytes high byte first and emits
  // on the end byte or a bad length byte. A sync byte inside a frame is plain data.
  crcdf_frame_ctrl u_frame_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .proceed (proceed),
    .res     (res)
  );

  // Result register. The whole pipeline advances only while it can take a new result,
  // which keeps the order of results and never drops one.
  crcdf_out_stage u_out_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .proceed          (proceed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_status (out_frame_status),
    .out_command_code (out_command_code),
    .out_reply_code   (out_reply_code),
    .out_reply_value  (out_reply_value)
  );

endmodule

[rtl/crcdf_checker.sv]
// Port-level checks of the deframer core, attached by a bind statement.
// Depends on crcdf_pkg and the assertion macros header.
`include "crc16_checked_reply_deframer_core_defines.svh"

module crcdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_frame_status,
  input logic [7:0]  out_command_code,
  input logic [7:0]  out_reply_code,
  input logic [15:0] out_reply_value
);
  import crcdf_pkg::*;

  logic        out_free;
  logic        len_err;
  logic [33:0] out_payload;
  logic        fields_zero;

  assign out_free    = !out_valid || !out_stall;
  assign len_err     = out_valid && (out_frame_status == ST_LEN_ERR);
  assign out_payload = {out_frame_status, out_command_code, out_reply_code, out_reply_value};
  assign fields_zero = (out_command_code == 8'h00) && (out_reply_code == 8'h00) &&
                       (out_reply_value == 16'h0000);

  // A stalled result stays presented and unchanged.
  `CRCDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  // A stalled input byte stays offered and unchanged.
  `CRCDF_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_rx_byte))

  // The input side is never stalled while the result register can move.
  `CRCDF_ASSERT_NOW(a_no_idle_stall, clk, rst_n, out_free, !in_stall)

  // A length error carries zeroed fields.
  `CRCDF_ASSERT_NOW(a_len_err_zero, clk, rst_n, len_err, fields_zero)

  // Reset leaves no result pending.
  `CRCDF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind crc16_checked_reply_deframer_core crcdf_checker u_crcdf_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for crc16_checked_reply_deframer_core: byte streams in, replies checked.
// Depends on rtl/crcdf_pkg.sv for the sync byte, length bounds, positions and status codes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crcdf_pkg::*;

  // Generous ceiling for a correct run with random gaps and stalls.
  localparam int CYCLE_LIMIT = 200000;
  // Frame bytes (sync, length and everything after) that the random traffic should reach.
  localparam int RANDOM_BYTES = 800;
  // Cycles allowed after the last reply.
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PERCENT = 19;

  typedef logic [7:0] byte_q_t[$];

  // How the check bytes of a generated frame are spoiled, if at all.
  typedef enum int {
    CHECK_GOOD,
    CHECK_BAD_HIGH,
    CHECK_BAD_LOW
  } check_mode_t;

  // One reply as the core should present it on the result channel.
  typedef struct {
    frame_status_t status;
    logic [7:0]    cmd;
    logic [7:0]    code;
    logic [15:0]   value;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_command_code;
  logic [7:0]  out_reply_code;
  logic [15:0] out_reply_value;

  crc16_checked_reply_deframer_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_status (out_frame_status),
    .out_command_code (out_command_code),
    .out_reply_code   (out_reply_code),
    .out_reply_value  (out_reply_value)
  );

  // Replies the deframer owes us, oldest first.
  reply_t replies_due[$];
  int     failures = 0;
  int     frame_bytes = 0;
  int     cycle_count = 0;
  // When set, neither side inserts gaps or stalls.
  logic   quiet = 1'b0;

  // Our own copy of the deframer state. Position 0 means the core is hunting for sync.
  int          hunt_pos;
  logic [7:0]  cur_len;
  logic [15:0] cur_crc;
  logic        cur_mismatch;
  logic [7:0]  cur_cmd;
  logic [7:0]  cur_code;
  logic [15:0] cur_value;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL crc16_checked_reply_deframer_core");
      $finish;
    end
  end

  // The result side stalls at random, changing only at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // CRC-16/XMODEM over one byte, MSB first, polynomial 0x1021.
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // Advances the predicted deframer by one accepted byte and queues any reply it causes.
  function automatic void deframe_byte(input logic [7:0] b);
    reply_t r;
    if (hunt_pos == POS_HUNT) begin
      // Anything but the sync byte is line noise and is simply dropped.
      if (b == SYNC_BYTE) begin
        frame_bytes++;
        hunt_pos     = POS_LEN;
        cur_len      = 8'h00;
        cur_crc      = CRC_INIT;
        cur_mismatch = 1'b0;
        cur_cmd      = 8'h00;
        cur_code     = 8'h00;
        cur_value    = 16'h0000;
      end
      return;
    end
    frame_bytes++;
    if (hunt_pos == POS_LEN) begin
      // A length outside the legal window is reported at once with zeroed fields.
      if (b < MIN_FRAME_LEN || b > MAX_FRAME_LEN) begin
        hunt_pos = POS_HUNT;
        cur_len  = 8'h00;
        r = '{status: ST_LEN_ERR, cmd: 8'h00, code: 8'h00, value: 16'h0000};
        replies_due.push_back(r);
        return;
      end
      cur_len  = b;
      cur_crc  = crc_next(CRC_INIT, b);
      hunt_pos = POS_CMD;
      return;
    end
    // Bytes 2..5 are captured whatever role they play, so short frames capture check bytes.
    case (hunt_pos)
      POS_CMD:    cur_cmd = b;
      POS_CODE:   cur_code = b;
      POS_VAL_LO: cur_value[7:0] = b;
      POS_VAL_HI: cur_value[15:8] = b;
      default: ;
    endcase
    if (hunt_pos < cur_len) begin
      cur_crc = crc_next(cur_crc, b);
    end else if (hunt_pos == cur_len) begin
      if (b != cur_crc[15:8]) cur_mismatch = 1'b1;
    end else if (hunt_pos == cur_len + 1) begin
      if (b != cur_crc[7:0]) cur_mismatch = 1'b1;
    end else begin
      // The byte after the check bytes closes the frame; its value does not matter.
      hunt_pos = POS_HUNT;
      r = '{status: cur_mismatch ? ST_CRC_ERR : ST_OK, cmd: cur_cmd, code: cur_code,
            value: cur_value};
      replies_due.push_back(r);
      return;
    end
    hunt_pos++;
  endfunction

  // Compares one reply transaction with the oldest expectation, field by field.
  function automatic void check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      $error("unexpected reply: frame_status %0d command_code %h", out_frame_status,
             out_command_code);
      failures++;
      return;
    end
    want = replies_due.pop_front();
    if (out_frame_status !== want.status) begin
      $error("frame_status: expected %0d, actual %0d", want.status, out_frame_status);
      failures++;
    end
    if (out_command_code !== want.cmd) begin
      $error("command_code: expected %h, actual %h", want.cmd, out_command_code);
      failures++;
    end
    if (out_reply_code !== want.code) begin
      $error("reply_code: expected %h, actual %h", want.code, out_reply_code);
      failures++;
    end
    if (out_reply_value !== want.value) begin
      $error("reply_value: expected %h, actual %h", want.value, out_reply_value);
      failures++;
    end
  endfunction

  // Outputs are sampled at the rising edge, before the core updates them.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_reply();
  end

  // Sends one byte. Called at a falling edge and returns at a falling edge, so that
  // in_valid stays high between back-to-back bytes and gets one assignment per step.
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    @(negedge clk);
  endtask

  task automatic send_bytes(input byte_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Frames the body (bytes 2..L-1) with sync, length, check bytes and an end byte,
  // optionally spoils one check byte, and sends the first keep bytes of the result.
  task automatic send_frame(input byte_q_t body, input check_mode_t mode, input int keep);
    byte_q_t     frame;
    logic [7:0]  flen;
    logic [15:0] crc;
    flen = 8'(body.size() + 2);
    crc  = crc_next(CRC_INIT, flen);
    foreach (body[i]) crc = crc_next(crc, body[i]);
    if (mode == CHECK_BAD_HIGH) crc[15:8] ^= 8'($urandom_range(1, 255));
    if (mode == CHECK_BAD_LOW) crc[7:0] ^= 8'($urandom_range(1, 255));
    frame = {SYNC_BYTE, flen, body, crc[15:8], crc[7:0], 8'($urandom_range(0, 255))};
    while (frame.size() > keep) void'(frame.pop_back());
    send_bytes(frame);
  endtask

  // Random body for a frame of length len; now and then a sync byte shows up as data.
  function automatic byte_q_t random_body(input int len);
    byte_q_t body;
    repeat (len - 2) begin
      body.push_back(($urandom_range(0, 9) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255)));
    end
    return body;
  endfunction

  // Mostly short frames, some longer ones, and now and then the longest legal one.
  function automatic int random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(MIN_FRAME_LEN, 12);
    if (pick < 95) return $urandom_range(13, MAX_FRAME_LEN - 1);
    return MAX_FRAME_LEN;
  endfunction

  // A sync byte and a length byte anywhere outside the legal window, on either side.
  task automatic send_bad_length();
    logic [7:0] bad;
    if ($urandom_range(0, 1)) bad = 8'($urandom_range(0, MIN_FRAME_LEN - 1));
    else bad = 8'($urandom_range(MAX_FRAME_LEN + 1, 255));
    send_bytes('{SYNC_BYTE, bad});
  endtask

  // Line noise while hunting, and lengths on both sides of the legal window.
  task automatic test_noise_and_bad_lengths();
    send_bytes('{8'h00, 8'hFF});
    send_bytes('{SYNC_BYTE, MIN_FRAME_LEN - 8'd1});
    send_bytes('{SYNC_BYTE, MAX_FRAME_LEN + 8'd1});
  endtask

  // Shortest frames, where check and end bytes land in the captured fields, one with a sync byte
  // as the command, one with a bad check byte; then extreme field values and a bad check byte.
  task automatic test_short_and_spoiled_frames();
    send_frame('{SYNC_BYTE}, CHECK_GOOD, 99);
    send_frame('{8'hFF}, CHECK_BAD_LOW, 99);
    send_frame('{8'h00, 8'hFF, 8'hFF, 8'hFF}, CHECK_BAD_HIGH, 99);
  endtask

  // Frames back to back with no gaps and no stalls, including the longest legal frame.
  task automatic test_back_to_back();
    quiet = 1'b1;
    send_frame(random_body(MAX_FRAME_LEN), CHECK_GOOD, 999);
    repeat (30) begin
      send_frame(random_body(random_length()), check_mode_t'($urandom_range(0, 2)), 999);
    end
    quiet = 1'b0;
  endtask

  // Mostly well-formed frames with random content; the rest are bad checks, bad lengths,
  // truncated frames that knock the core out of step, and raw noise.
  task automatic test_random_traffic();
    int start;
    int pick;
    int len;
    start = frame_bytes;
    while (frame_bytes - start < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      len  = random_length();
      if (pick < 62) begin
        send_frame(random_body(len), CHECK_GOOD, 999);
      end else if (pick < 72) begin
        send_frame(random_body(len),
                   $urandom_range(0, 1) ? CHECK_BAD_HIGH : CHECK_BAD_LOW, 999);
      end else if (pick < 80) begin
        send_bad_length();
      end else if (pick < 88) begin
        send_frame(random_body(len), CHECK_GOOD, $urandom_range(1, len + 2));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    hunt_pos     = POS_HUNT;
    cur_len      = 8'h00;
    cur_crc      = CRC_INIT;
    cur_mismatch = 1'b0;
    cur_cmd      = 8'h00;
    cur_code     = 8'h00;
    cur_value    = 16'h0000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_noise_and_bad_lengths();
    test_short_and_spoiled_frames();
    test_back_to_back();
    test_random_traffic();

    // Stimulus is done; let every owed reply arrive, then give the core a little longer
    // to show anything it should not.
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("PASS crc16_checked_reply_deframer_core");
    end else begin
      $display("FAIL crc16_checked_reply_deframer_core");
    end
    $finish;
  end

endmodule
